@@ design/swsr_pkg.sv @@
`timescale 1ns / 1ps

package swsr_pkg;

  // Bits in one decoded byte.
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int unsigned BYTE_IDX_W    = 3;
  localparam int unsigned TICK_W        = 16;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Largest byte count a read may ask for.
  localparam logic [3:0] MAX_BYTES = 4'd8;

  // Configuration register indexes.
  localparam logic [2:0] CFG_START_LOW  = 3'd0;
  localparam logic [2:0] CFG_START_HIGH = 3'd1;
  localparam logic [2:0] CFG_TIMEOUT    = 3'd2;
  localparam logic [2:0] CFG_THRESHOLD  = 3'd3;
  localparam logic [2:0] CFG_BYTES      = 3'd4;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_START_LOW  = 7'b0000010,
    PH_START_HIGH = 7'b0000100,
    PH_RESP_LOW   = 7'b0001000,
    PH_RESP_HIGH  = 7'b0010000,
    PH_BIT_GAP    = 7'b0100000,
    PH_BIT_HIGH   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  start_high_ticks;
    logic [7:0]  response_timeout;
    logic [7:0]  one_threshold;
    logic [3:0]  bytes_per_read;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       last_byte;
    logic       fail;
  } result_t;

endpackage

@@ design/swsr_core.sv @@
`timescale 1ns / 1ps

module swsr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             start_request,
  input  logic             line_level,
  input  swsr_pkg::cfg_t   cfg,
  output swsr_pkg::result_t res
);
  import swsr_pkg::*;

  phase_t                phase_r,      phase_nxt;
  logic [TICK_W-1:0]     tick_r,       tick_nxt;
  logic [BIT_IDX_W-1:0]  bit_index_r,  bit_index_nxt;
  logic [7:0]            shift_r,      shift_nxt;
  logic [BYTE_IDX_W-1:0] byte_index_r, byte_index_nxt;

  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] timeout_ext;
  logic [3:0]        bytes_eff;
  logic              bit_val;
  logic [7:0]        shift_new;
  logic              wait_level;
  logic              is_last;

  always_comb begin
    tick_inc    = (tick_r == TICK_MAX) ? tick_r : tick_r + 1'b1;
    timeout_ext = {{(TICK_W-8){1'b0}}, cfg.response_timeout};
    if (cfg.bytes_per_read == 4'd0) begin
      bytes_eff = 4'd1;
    end else if (cfg.bytes_per_read > MAX_BYTES) begin
      bytes_eff = MAX_BYTES;
    end else begin
      bytes_eff = cfg.bytes_per_read;
    end
    bit_val    = tick_r > {{(TICK_W-8){1'b0}}, cfg.one_threshold};
    shift_new  = {shift_r[6:0], bit_val};
    // The response-high phase ends on a low level, the others on a high level.
    wait_level = (phase_r != PH_RESP_HIGH);
    is_last    = ({1'b0, byte_index_r} + 4'd1) >= bytes_eff;
  end

  always_comb begin
    phase_nxt      = phase_r;
    tick_nxt       = tick_r;
    bit_index_nxt  = bit_index_r;
    shift_nxt      = shift_r;
    byte_index_nxt = byte_index_r;
    res            = '0;
    res.busy_res   = 1'b1;

    unique case (phase_r)
      PH_START_LOW: begin
        res.drive_low = 1'b1;
        tick_nxt      = tick_inc;
        if (tick_inc >= cfg.start_low_ticks) begin
          tick_nxt  = '0;
          phase_nxt = (cfg.start_high_ticks == 8'd0) ? PH_RESP_LOW : PH_START_HIGH;
        end
      end
      PH_START_HIGH: begin
        tick_nxt = tick_inc;
        if (tick_inc >= {{(TICK_W-8){1'b0}}, cfg.start_high_ticks}) begin
          tick_nxt  = '0;
          phase_nxt = PH_RESP_LOW;
        end
      end
      PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_GAP: begin
        if (line_level == wait_level) begin
          if (phase_r == PH_RESP_LOW) begin
            phase_nxt = PH_RESP_HIGH;
            tick_nxt  = '0;
          end else if (phase_r == PH_RESP_HIGH) begin
            phase_nxt = PH_BIT_GAP;
            tick_nxt  = '0;
          end else begin
            // The edge tick already counts toward the high pulse.
            phase_nxt = PH_BIT_HIGH;
            tick_nxt  = {{(TICK_W-1){1'b0}}, 1'b1};
          end
        end else begin
          tick_nxt = tick_inc;
          if (tick_inc >= timeout_ext) begin
            res.fail       = 1'b1;
            phase_nxt      = PH_IDLE;
            tick_nxt       = '0;
            bit_index_nxt  = '0;
            shift_nxt      = '0;
            byte_index_nxt = '0;
          end
        end
      end
      PH_BIT_HIGH: begin
        if (line_level) begin
          tick_nxt = tick_inc;
          if (tick_inc >= timeout_ext) begin
            res.fail       = 1'b1;
            phase_nxt      = PH_IDLE;
            tick_nxt       = '0;
            bit_index_nxt  = '0;
            shift_nxt      = '0;
            byte_index_nxt = '0;
          end
        end else begin
          tick_nxt  = '0;
          phase_nxt = PH_BIT_GAP;
          shift_nxt = shift_new;
          if (bit_index_r == BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
            res.byte_valid = 1'b1;
            res.byte_value = shift_new;
            res.last_byte  = is_last;
            bit_index_nxt  = '0;
            shift_nxt      = '0;
            if (is_last) begin
              phase_nxt      = PH_IDLE;
              byte_index_nxt = '0;
            end else begin
              byte_index_nxt = byte_index_r + 1'b1;
            end
          end else begin
            bit_index_nxt = bit_index_r + 1'b1;
          end
        end
      end
      default: begin
        // Idle, and any code that is not a valid phase.
        phase_nxt      = PH_IDLE;
        tick_nxt       = '0;
        bit_index_nxt  = '0;
        shift_nxt      = '0;
        byte_index_nxt = '0;
        if (start_request) begin
          res.drive_low = 1'b1;
          if (cfg.start_low_ticks <= TICK_W'(1)) begin
            phase_nxt = (cfg.start_high_ticks == 8'd0) ? PH_RESP_LOW : PH_START_HIGH;
          end else begin
            tick_nxt  = TICK_W'(1);
            phase_nxt = PH_START_LOW;
          end
        end else begin
          res.busy_res = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_r       <= '0;
      bit_index_r  <= '0;
      shift_r      <= '0;
      byte_index_r <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      tick_r       <= tick_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_r      <= shift_nxt;
      byte_index_r <= byte_index_nxt;
    end
  end

  a_fail_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.fail |=> phase_r == PH_IDLE && byte_index_r == '0)
    else $error("fail beat did not end the read");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.last_byte |=> phase_r == PH_IDLE)
    else $error("last byte did not end the read");

  a_last_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    res.last_byte |-> res.byte_valid && !res.fail)
    else $error("last byte flag without a completed byte");

  a_bits_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    bit_index_r != '0 |-> phase_r == PH_BIT_GAP || phase_r == PH_BIT_HIGH)
    else $error("bit count left over outside the data phases");

endmodule

@@ design/single_wire_sensor_reader_unit.sv @@
`timescale 1ns / 1ps

// Single-wire sensor reader: pulse-width decoder for one-wire humidity style sensors.
// Feed one input beat per timer tick (typically one microsecond) on the in_ channel:
// tdata bit 0 requests a read, bit 1 is the sampled data line level. Every input beat
// produces exactly one output beat on the out_ channel, which carries the line drive,
// a busy flag, the decoded byte with its valid strobe, and a fail strobe; out_tlast
// marks the final byte of a read.
// Registered output: a beat accepted at an edge shows on out_ in the next cycle.
// Throughput is one beat per cycle while out_tready is high; the sequencer state and
// the output register both update at the accepting edge, so input beats may arrive
// back to back. When the receiver stalls, the output register holds its beat and
// in_tready stays high only if that beat is being taken in the same cycle, so nothing
// is lost. Users write configuration registers via cfg_ only when idle (unenforced).
// Reset (synchronous, rst_n low) returns the sequencer to idle, empties the output
// register and restores the default timing: a 25000-tick start pulse, 25 ticks high,
// a 100-tick phase timeout, a one-threshold of 50 ticks and five bytes per read.
module single_wire_sensor_reader_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] start_request, [1] line_level, [7:2] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] drive_low, [1] busy_res, [9:2] byte_value, [10] byte_valid, [11] fail,
  // [15:12] zero
  output logic [15:0] out_tdata,
  output logic        out_tlast,  // last_byte
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import swsr_pkg::*;

  cfg_t    cfg_r;
  result_t res;
  logic    accept;
  logic    out_tvalid_r;
  result_t out_res_r;

  // A new beat is taken whenever the output register is empty or being drained.
  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  swsr_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (accept),
    .start_request (in_tdata[0]),
    .line_level    (in_tdata[1]),
    .cfg           (cfg_r),
    .res           (res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_ticks  <= 16'd25000;
      cfg_r.start_high_ticks <= 8'd25;
      cfg_r.response_timeout <= 8'd100;
      cfg_r.one_threshold    <= 8'd50;
      cfg_r.bytes_per_read   <= 4'd5;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START_LOW:  cfg_r.start_low_ticks  <= cfg_wdata;
        CFG_START_HIGH: cfg_r.start_high_ticks <= cfg_wdata[7:0];
        CFG_TIMEOUT:    cfg_r.response_timeout <= cfg_wdata[7:0];
        CFG_THRESHOLD:  cfg_r.one_threshold    <= cfg_wdata[7:0];
        CFG_BYTES:      cfg_r.bytes_per_read   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Output register: valid is control state, the payload loads on accept only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_res_r.fail, out_res_r.byte_valid,
                       out_res_r.byte_value, out_res_r.busy_res, out_res_r.drive_low};
  assign out_tlast  = out_res_r.last_byte;

endmodule
